// File: hw/rtl/nlss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlss_pkg: shared types and constants of the nearest lower symbol search
// Payload structs of the request and response channels, the token passed
// along the cell chain, the table write bus and the symbol type rules.
// ----------------------------------------------------------------------------
package nlss_pkg;

   // request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // symbol type rules
   localparam logic [7:0] TYPE_DEBUG_MASK = 8'hE0;
   localparam logic [7:0] TYPE_GLOBAL_BIT = 8'h01;
   localparam logic [7:0] TYPE_FILE_NAME  = 8'h1F;

   // distance reported when nothing qualifies
   localparam logic [30:0] DIST_NONE = 31'h7FFF_FFFF;

   // width of the symbol count register
   localparam int COUNT_W = 9;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         entry_index;
      logic signed [31:0] address_value;
      logic [7:0]         symbol_type;
      logic               skip_lookup;
   } req_payload_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  symbol_index;
      logic [30:0] distance;
   } rsp_payload_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic               skip;
      logic signed [31:0] addr;
      logic               hit;
      logic [7:0]         idx;
      logic [30:0]        best_dist;
   } token_type;

   // table write bus broadcast to every cell
   typedef struct packed {
      logic               en;
      logic [7:0]         index;
      logic signed [31:0] value;
      logic [7:0]         stype;
   } wr_bus_type;

   // global, not debug, not a file name
   function automatic logic eligible(input logic [7:0] t);
      logic ok;
      ok = ((t & TYPE_DEBUG_MASK) == 8'h00)
           && ((t & TYPE_GLOBAL_BIT) != 8'h00)
           && (t != TYPE_FILE_NAME);
      return ok;
   endfunction

endpackage

// File: hw/rtl/nlss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlss_cell: one symbol table slot of the search chain
// Holds one symbol value and type; updates a passing unskipped token when
// its eligible, in-count entry is closer at or below the searched address.
// ----------------------------------------------------------------------------
module nlss_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nlss_pkg::wr_bus_type              wr_bus,
   input  logic [nlss_pkg::COUNT_W-1:0]      symbol_count,
   input  nlss_pkg::token_type               token_up,
   output nlss_pkg::token_type               token_down
);

   localparam logic [31:0] CELL_POS = 32'(CELL_INDEX);
   localparam logic [7:0]  CELL_TAG = CELL_POS[7:0];

   logic signed [31:0]  value_ff;
   logic [7:0]          stype_ff;
   logic                tok_valid_ff;
   nlss_pkg::token_type tok_ff;
   nlss_pkg::token_type tok_in;
   logic signed [32:0]  diff;
   logic                in_range;
   logic                take;

   // entry storage, written by a load that names this slot
   always_ff @(posedge clock) begin
      if (wr_bus.en && ({24'd0, wr_bus.index} == CELL_POS)) begin
         value_ff <= wr_bus.value;
         stype_ff <= wr_bus.stype;
      end
   end

   // exact distance, one bit wider so it cannot wrap
   assign diff     = {token_up.addr[31], token_up.addr} - {value_ff[31], value_ff};
   assign in_range = CELL_POS < {{(32 - nlss_pkg::COUNT_W){1'b0}}, symbol_count};
   assign take     = token_up.valid && !token_up.skip && in_range
                     && nlss_pkg::eligible(stype_ff) && !diff[32]
                     && (diff[31:0] < {1'b0, token_up.best_dist});

   // next token
   always_comb begin
      tok_in = token_up;
      if (take) begin
         tok_in.hit       = 1'b1;
         tok_in.idx       = CELL_TAG;
         tok_in.best_dist = diff[30:0];
      end
   end

   // token valid
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= token_up.valid;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   always_comb begin
      token_down       = tok_ff;
      token_down.valid = tok_valid_ff;
   end

endmodule

// File: hw/rtl/nearest_lower_symbol_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_lower_symbol_search_top: nearest predecessor symbol lookup
// Symbol table kept in a chain of cells; a query token walks the chain and
// leaves with the closest eligible symbol at or below the address.
// ----------------------------------------------------------------------------
// A load writes one table slot and its response (the not-found pattern) is
// registered in the pending-result register, then in the response register.
// A query passes through a chain of TABLE_DEPTH cells, one cell per cycle,
// then through the same pending-result and response registers; one query
// is in the chain at a time. The pending-result register in front of the
// response register lets the next request transfer while an earlier
// response still waits to be taken. csr_ready is always high; symbol_count
// must be written while idle. Slots at index 256 and above are never loaded.
module nearest_lower_symbol_search_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  nlss_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output nlss_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nlss_pkg::COUNT_W-1:0]  csr_data
);

   logic [nlss_pkg::COUNT_W-1:0] count_ff;
   logic                         busy_ff;
   logic                         busy_in;
   logic                         pend_valid_ff;
   logic                         pend_valid_in;
   nlss_pkg::rsp_payload_type    pend_ff;
   nlss_pkg::rsp_payload_type    pend_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   nlss_pkg::rsp_payload_type    rsp_ff;
   logic                         req_xfer;
   logic                         is_query;
   logic                         move_out;
   nlss_pkg::wr_bus_type         wr_bus;
   nlss_pkg::token_type          chain [TABLE_DEPTH+1];
   nlss_pkg::token_type          done_tok;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff && !pend_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign is_query  = (req_payload.req_type == nlss_pkg::REQ_QUERY);
   assign done_tok  = chain[TABLE_DEPTH];
   assign move_out  = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   // symbol count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // table write bus
   always_comb begin
      wr_bus.en    = req_xfer && (req_payload.req_type == nlss_pkg::REQ_LOAD);
      wr_bus.index = req_payload.entry_index;
      wr_bus.value = req_payload.address_value;
      wr_bus.stype = req_payload.symbol_type;
   end

   // query token injected at the head of the chain
   always_comb begin
      chain[0].valid     = req_xfer && is_query;
      chain[0].skip      = req_payload.skip_lookup;
      chain[0].addr      = req_payload.address_value;
      chain[0].hit       = 1'b0;
      chain[0].idx       = 8'd0;
      chain[0].best_dist = nlss_pkg::DIST_NONE;
   end

   // cell chain
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      nlss_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr_bus       (wr_bus),
         .symbol_count (count_ff),
         .token_up     (chain[g]),
         .token_down   (chain[g+1])
      );
   end

   // busy while a query token is in the chain
   always_comb begin
      busy_in = busy_ff;
      if (req_xfer && is_query) begin
         busy_in = 1'b1;
      end else if (done_tok.valid) begin
         busy_in = 1'b0;
      end
   end

   // pending result: load response or finished query
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (move_out) begin
         pend_valid_in = 1'b0;
      end
      if (req_xfer && !is_query) begin
         pend_valid_in         = 1'b1;
         pend_in.found         = 1'b0;
         pend_in.symbol_index  = 8'd0;
         pend_in.distance      = nlss_pkg::DIST_NONE;
      end else if (done_tok.valid) begin
         pend_valid_in         = 1'b1;
         pend_in.found         = done_tok.hit;
         pend_in.symbol_index  = done_tok.hit ? done_tok.idx : 8'd0;
         pend_in.distance      = done_tok.best_dist;
      end
   end

   // response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (move_out) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a finished token always belongs to an outstanding query
   a_done_while_busy : assert property (@(posedge clock) disable iff (reset)
      done_tok.valid |-> busy_ff)
      else $error("query token left the chain with no query outstanding");

   // a finished query frees the chain
   a_done_clears_busy : assert property (@(posedge clock) disable iff (reset)
      done_tok.valid |=> !busy_ff)
      else $error("busy still set after the query token left the chain");

   // a query transfer occupies the chain
   a_query_sets_busy : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_query) |=> busy_ff)
      else $error("query transfer did not mark the chain busy");

   // a blocked pending result is held
   a_pend_holds : assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_valid_ff && !rsp_ready) |=> (pend_valid_ff && $stable(pend_ff)))
      else $error("pending result lost while the response was stalled");

   // not-found responses carry slot zero
   a_not_found_slot : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.symbol_index == 8'd0))
      else $error("not-found response carries a nonzero slot");

endmodule
